@@ hdl/cfwt_pkg.sv @@
// ----------------------------------------------------------------------------
// cfwt_pkg
// Shared widths and payload types for the closest fixed-weight word block.
// ----------------------------------------------------------------------------
package cfwt_pkg;

    localparam int WORD_W = 64;   // payload word width on the channels
    localparam int CFG_W  = 7;    // target weight register width

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CFG_W-1:0]  t_cfg;

endpackage

@@ hdl/cfwt_in_if.sv @@
// ----------------------------------------------------------------------------
// cfwt_in_if
// Request channel carrying one input word.
// ----------------------------------------------------------------------------
interface cfwt_in_if;
    import cfwt_pkg::*;

    logic  valid;
    logic  ready;
    t_word word_in;

    modport source (output valid, output word_in, input ready);
    modport sink   (input valid, input word_in, output ready);

endinterface

@@ hdl/cfwt_out_if.sv @@
// ----------------------------------------------------------------------------
// cfwt_out_if
// Result channel carrying one adjusted word.
// ----------------------------------------------------------------------------
interface cfwt_out_if;
    import cfwt_pkg::*;

    logic  valid;
    logic  ready;
    t_word word_out;

    modport source (output valid, output word_out, input ready);
    modport sink   (input valid, input word_out, output ready);

endinterface

@@ hdl/cfwt_adjust.sv @@
// ----------------------------------------------------------------------------
// cfwt_adjust
// Trims the lowest ones or fills the lowest zeros until the weight matches.
// ----------------------------------------------------------------------------
module cfwt_adjust #(
    parameter int W  = 64,
    parameter int CW = 7
) (
    input  logic [W-1:0]  i_word,
    input  logic [CW-1:0] i_want,
    output logic [W-1:0]  o_word,
    output logic          o_trim
);

    logic [CW-1:0] have;
    logic [CW-1:0] deficit;
    logic [CW-1:0] hi_cnt  [W];
    logic [CW-1:0] zero_lo [W];

    assign have    = CW'($countones(i_word));
    assign deficit = i_want - have;
    assign o_trim  = (have > i_want);

    // per bit: ones at or above it, and zeros below it
    always_comb begin
        for (int i = 0; i < W; i++) begin
            hi_cnt[i]  = CW'($countones(i_word >> i));
            zero_lo[i] = CW'(i) - (have - hi_cnt[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < W; i++) begin
            if (have > i_want) begin
                // keep only the top i_want ones
                o_word[i] = i_word[i] && (hi_cnt[i] <= i_want);
            end else if (have < i_want) begin
                o_word[i] = i_word[i] || (zero_lo[i] < deficit);
            end else begin
                o_word[i] = i_word[i];
            end
        end
    end

endmodule

@@ hdl/cfwt_prep.sv @@
// ----------------------------------------------------------------------------
// cfwt_prep
// Decides whether the trimmed word advances, and prepares the successor terms.
// ----------------------------------------------------------------------------
module cfwt_prep #(
    parameter int W  = 64,
    parameter int CW = 7,
    parameter int SW = 6
) (
    input  logic [W-1:0]  i_word,
    input  logic [CW-1:0] i_want,
    input  logic          i_trim,
    output logic [W-1:0]  o_fill,
    output logic [SW-1:0] o_ctz,
    output logic          o_take
);

    logic [W-1:0] top;
    logic [W-1:0] low_one;

    // i_want ones packed at the top of the word
    assign top     = ~({W{1'b1}} >> i_want);
    assign o_take  = i_trim && (i_word != '0) && (i_word < top);
    assign o_fill  = i_word | (i_word - W'(1));
    assign low_one = i_word & (~i_word + W'(1));

    always_comb begin
        o_ctz = '0;
        for (int i = 0; i < W; i++) begin
            if (low_one[i]) begin
                o_ctz = o_ctz | SW'(i);
            end
        end
    end

endmodule

@@ hdl/cfwt_step.sv @@
// ----------------------------------------------------------------------------
// cfwt_step
// Next larger word of the same weight, applied when the prep stage asks.
// ----------------------------------------------------------------------------
module cfwt_step #(
    parameter int W  = 64,
    parameter int SW = 6
) (
    input  logic [W-1:0]  i_word,
    input  logic [W-1:0]  i_fill,
    input  logic [SW-1:0] i_ctz,
    input  logic          i_take,
    output logic [W-1:0]  o_word
);

    logic [W:0]   inc;
    logic [W:0]   low;
    logic [W-1:0] succ;

    assign inc  = {1'b0, i_fill} + (W+1)'(1);
    // ones below the lowest zero of i_fill, shifted down by i_ctz
    assign low  = (({1'b0, i_fill} ^ inc) >> 1) >> i_ctz;
    assign succ = inc[W-1:0] | low[W:1];

    assign o_word = i_take ? succ : i_word;

endmodule

@@ hdl/closest_fixed_weight_word.sv @@
// A request accepted into the input register passes through the adjust and prep
// registers and has its result valid on o_out once it reaches the result register.
// Throughput: one word per cycle; the four pipeline registers (input, adjust,
// prep, result) each hold one word and stall only when the result is not taken.
// Reset: clears all stage valids and sets target_weight to 0.
// ----------------------------------------------------------------------------
// closest_fixed_weight_word
// Rounds each word to a nearby word with the configured number of ones.
// ----------------------------------------------------------------------------
module closest_fixed_weight_word
    import cfwt_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg             i_cfg_wdata,
    cfwt_in_if.sink          i_in,
    cfwt_out_if.source       o_out
);

    localparam int CW = $clog2(WORD_BITS + 1);
    localparam int SW = $clog2(WORD_BITS);

    t_cfg                 r_target_weight;

    logic                 r_v0, r_v1, r_v2, r_v3;
    logic                 rdy0, rdy1, rdy2, rdy3;

    logic [WORD_BITS-1:0] r_x0, r_x1, r_x2, r_x3;
    logic [CW-1:0]        r_want0, r_want1;
    logic                 r_trim1;
    logic [WORD_BITS-1:0] r_fill2;
    logic [SW-1:0]        r_ctz2;
    logic                 r_take2;

    logic [CW-1:0]        n_want0;
    logic [WORD_BITS-1:0] n_x1;
    logic                 n_trim1;
    logic [WORD_BITS-1:0] n_fill2;
    logic [SW-1:0]        n_ctz2;
    logic                 n_take2;
    logic [WORD_BITS-1:0] n_x3;

    // target above the word width saturates
    assign n_want0 = (r_target_weight > CFG_W'(WORD_BITS)) ? CW'(WORD_BITS)
                                                            : CW'(r_target_weight);

    assign rdy3 = !r_v3 || o_out.ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;

    assign i_in.ready     = rdy0;
    assign o_out.valid    = r_v3;
    assign o_out.word_out = WORD_W'(r_x3);

    cfwt_adjust #(.W(WORD_BITS), .CW(CW)) u_adjust (
        .i_word (r_x0),
        .i_want (r_want0),
        .o_word (n_x1),
        .o_trim (n_trim1)
    );

    cfwt_prep #(.W(WORD_BITS), .CW(CW), .SW(SW)) u_prep (
        .i_word (r_x1),
        .i_want (r_want1),
        .i_trim (r_trim1),
        .o_fill (n_fill2),
        .o_ctz  (n_ctz2),
        .o_take (n_take2)
    );

    cfwt_step #(.W(WORD_BITS), .SW(SW)) u_step (
        .i_word (r_x2),
        .i_fill (r_fill2),
        .i_ctz  (r_ctz2),
        .i_take (r_take2),
        .o_word (n_x3)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_weight <= '0;
            r_v0            <= 1'b0;
            r_v1            <= 1'b0;
            r_v2            <= 1'b0;
            r_v3            <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_target_weight <= i_cfg_wdata;
            end
            if (rdy0) begin
                r_v0 <= i_in.valid;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0 && i_in.valid) begin
            r_x0    <= i_in.word_in[WORD_BITS-1:0];
            r_want0 <= n_want0;
        end
        if (rdy1 && r_v0) begin
            r_x1    <= n_x1;
            r_want1 <= r_want0;
            r_trim1 <= n_trim1;
        end
        if (rdy2 && r_v1) begin
            r_x2    <= r_x1;
            r_fill2 <= n_fill2;
            r_ctz2  <= n_ctz2;
            r_take2 <= n_take2;
        end
        if (rdy3 && r_v2) begin
            r_x3    <= n_x3;
        end
    end

endmodule

@@ sim/tb_closest_fixed_weight_word.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_closest_fixed_weight_word
// Self-checking bench for the fixed-weight word rounding block: a table of
// corner words under several target weights, then randomized phases with
// words biased toward the target weight, random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_closest_fixed_weight_word;
    import cfwt_pkg::*;

    localparam int WB          = WORD_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 142;
    localparam int CALM_FIRST  = 700;
    localparam int CALM_LAST   = 1000;

    typedef struct packed {
        t_cfg  weight;
        t_word word;
        bit    fixed;     // result typed in below instead of predicted
        t_word result;
    } t_dir_row;

    localparam t_word ONES = {WB{1'b1}};
    localparam t_word MSB1 = t_word'(1) << (WB - 1);

    t_dir_row dir_rows [20] = '{
        '{7'd0,   ONES,                   1'b1, 64'h0},
        '{7'd0,   64'h0,                  1'b1, 64'h0},
        '{7'd0,   MSB1,                   1'b1, 64'h0},
        '{7'd64,  64'h0,                  1'b1, ONES},
        '{7'd64,  64'h1234_5678_9ABC_DEF0, 1'b1, ONES},
        '{7'd127, 64'h0,                  1'b1, ONES},
        '{7'd65,  64'h5555_5555_5555_5555, 1'b1, ONES},
        '{7'd1,   ONES,                   1'b1, MSB1},
        '{7'd1,   64'h3,                  1'b0, 64'h0},
        '{7'd1,   64'h1,                  1'b1, 64'h1},
        '{7'd32,  64'h0,                  1'b1, 64'h0000_0000_FFFF_FFFF},
        '{7'd32,  ONES,                   1'b1, 64'hFFFF_FFFF_0000_0000},
        '{7'd32,  64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA},
        '{7'd32,  64'hF0F0_F0F0_F0F0_F0F1, 1'b0, 64'h0},
        '{7'd63,  MSB1,                   1'b0, 64'h0},
        '{7'd63,  ONES,                   1'b0, 64'h0},
        '{7'd2,   64'hF,                  1'b0, 64'h0},
        '{7'd2,   64'hE000_0000_0000_0000, 1'b0, 64'h0},
        '{7'd5,   64'h0000_0000_0000_00FF, 1'b0, 64'h0},
        '{7'd40,  64'h0123_4567_89AB_CDEF, 1'b0, 64'h0}
    };

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    t_cfg  cfg_wdata;

    cfwt_in_if  in_ch ();
    cfwt_out_if out_ch ();

    closest_fixed_weight_word dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    t_word want_words [$];
    t_cfg  cur_weight;
    bit    calm;
    int    n_sent;
    int    n_checked = 0;
    int    n_bad = 0;
    int    n_weights;
    int    cycles = 0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int low_zeros(t_word v);
        int n;
        n = 0;
        while (n < WB && !v[n]) n++;
        return n;
    endfunction

    function automatic t_word round_to_weight(t_word w, t_cfg tgt);
        int    want;
        int    have;
        t_word x;
        t_word top;
        t_word t;
        t_word nt;
        t_word low;
        x    = w;
        want = (int'(tgt) > WB) ? WB : int'(tgt);
        have = $countones(x);
        if (have > want) begin
            top = (want == 0) ? t_word'(0) : (ONES << (WB - want));
            for (int i = 0; i < WB && have > want; i++) begin
                if (x[i]) begin
                    x[i] = 1'b0;
                    have--;
                end
            end
            if (x < top && x != 0) begin
                // next larger word with the same count of ones
                t   = x | (x - 1);
                nt  = ~t;
                low = (nt & (t_word'(0) - nt)) - 1;
                low = (low >> low_zeros(x)) >> 1;
                x   = (t + 1) | low;
            end
        end else if (have < want) begin
            for (int i = 0; i < WB && have < want; i++) begin
                if (!x[i]) begin
                    x[i] = 1'b1;
                    have++;
                end
            end
        end
        return x;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_word make_word(t_cfg tgt);
        t_word w;
        int    k;
        int    mode;
        w    = {$urandom, $urandom};
        mode = $urandom_range(0, 9);
        if (mode >= 3 && mode <= 7) begin
            // popcount close to the target, to hit all three branches often
            k = (int'(tgt) > WB) ? WB : int'(tgt);
            k = k + $urandom_range(0, 6) - 3;
            if (k < 0) k = 0;
            if (k > WB) k = WB;
            w = '0;
            while ($countones(w) < k) w[$urandom_range(0, WB - 1)] = 1'b1;
        end else if (mode == 8) begin
            if ($urandom_range(0, 1))
                w = w & {$urandom, $urandom} & {$urandom, $urandom};
            else
                w = w | {$urandom, $urandom} | {$urandom, $urandom};
        end else if (mode == 9) begin
            k = $urandom_range(0, WB);
            case ($urandom_range(0, 3))
                0: w = '0;
                1: w = ONES;
                2: w = (k == 0) ? t_word'(0) : (ONES >> (WB - k));
                default: w = (k == 0) ? t_word'(0) : (ONES << (WB - k));
            endcase
        end
        return w;
    endfunction

    task automatic push_word(input t_word w, input t_word result);
        bit took;
        while (!calm && $urandom_range(0, 99) < 6) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.word_in <= w;
        took = 1'b0;
        while (!took) begin
            @(negedge clk);
            took = in_ch.ready;
            if (took) want_words = {want_words, result};
            @(posedge clk);
        end
        n_sent++;
    endtask

    // register writes only once the pipeline has emptied
    task automatic set_weight(input t_cfg w);
        in_ch.valid <= 1'b0;
        while (want_words.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we     <= 1'b0;
        cur_weight = w;
        n_weights++;
    endtask

    task automatic report_mismatch(input string what, input t_word got, input t_word exp_w);
        n_bad++;
        $display("MISMATCH %0s: got %h expected %h (request %0d)", what, got, exp_w, n_checked);
    endtask

    // ------------------------------------------------------------------------
    // Clock, sink, checker, watchdog
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 6);
    end

    always @(negedge clk) begin : result_check
        t_word head;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (want_words.size() == 0) begin
                report_mismatch("unexpected result", out_ch.word_out, '0);
            end else begin
                head = want_words.pop_front();
                n_checked++;
                if (out_ch.word_out !== head)
                    report_mismatch("word_out", out_ch.word_out, head);
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending", cycles,
                     want_words.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_word w;
        t_cfg  ph_weight;
        int    idx;
        in_ch.valid   <= 1'b0;
        in_ch.word_in <= '0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        rst_n         <= 1'b0;
        cur_weight = '0;
        calm       = 1'b0;
        n_sent     = 0;
        n_weights  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner words; the first rows run on the reset weight of zero
        foreach (dir_rows[r]) begin
            if (dir_rows[r].weight != cur_weight) set_weight(dir_rows[r].weight);
            push_word(dir_rows[r].word, dir_rows[r].fixed ? dir_rows[r].result :
                      round_to_weight(dir_rows[r].word, cur_weight));
        end

        idx = 0;
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: ph_weight = 7'd1;
                1: ph_weight = 7'd63;
                2: ph_weight = 7'd64;
                3: ph_weight = 7'd0;
                4: ph_weight = 7'd127;
                5: ph_weight = 7'd32;
                6: ph_weight = 7'd2;
                7: ph_weight = 7'd65;
                default: ph_weight = ($urandom_range(0, 4) == 0) ?
                                     t_cfg'($urandom_range(65, 127)) :
                                     t_cfg'($urandom_range(0, WB));
            endcase
            set_weight(ph_weight);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                calm = (idx >= CALM_FIRST && idx < CALM_LAST);
                w = make_word(cur_weight);
                push_word(w, round_to_weight(w, cur_weight));
                idx++;
            end
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;

        while (want_words.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d requests over %0d weight settings (0, 1, 2, 32, 63, 64, above 64)",
                 n_sent, n_weights);
        $display("Checked %0d results, %0d mismatches", n_checked, n_bad);
        if (n_bad == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ closest_fixed_weight_word.f @@
hdl/cfwt_pkg.sv
hdl/cfwt_in_if.sv
hdl/cfwt_out_if.sv
hdl/cfwt_adjust.sv
hdl/cfwt_prep.sv
hdl/cfwt_step.sv
hdl/closest_fixed_weight_word.sv
sim/tb_closest_fixed_weight_word.sv
